FILE: rtl/sspq_pkg.sv
// ----------------------------------------------------------------------------
// sspq_pkg: shared types and constants of the stable sorted priority queue
// Holds the sizing constants, the status codes and the word layouts
// used by the channels, the cells and the checker.
// ----------------------------------------------------------------------------
package sspq_pkg;

   // Number of entries held by the cell chain.
   localparam int DEPTH        = 16;
   // Width of the stored handle; the handle word on the channel is 16 bits.
   localparam int HANDLE_WIDTH = 16;

   localparam int KEY_W       = 32;
   localparam int PAYLOAD_W   = 16;
   localparam int COUNT_OUT_W = 5;
   localparam int HANDLE_KEEP_W = (HANDLE_WIDTH < PAYLOAD_W) ? HANDLE_WIDTH : PAYLOAD_W;
   localparam int COUNT_W     = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   // Request word.
   typedef struct packed {
      op_type                    op;
      logic signed [KEY_W-1:0]   key;
      logic [PAYLOAD_W-1:0]      payload;
   } req_word_type;

   // Response word.
   typedef struct packed {
      logic                      out_valid;
      logic signed [KEY_W-1:0]   out_key;
      logic [PAYLOAD_W-1:0]      out_payload;
      status_type                status;
      logic                      empty_res;
      logic [COUNT_OUT_W-1:0]    count;
   } rsp_word_type;

   // One stored entry.
   typedef struct packed {
      logic signed [KEY_W-1:0]   key;
      logic [HANDLE_KEEP_W-1:0]  handle;
   } entry_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic      enq;
      logic      deq;
      entry_type item;
   } cell_cmd_type;

endpackage

FILE: rtl/sspq_req_if.sv
// ----------------------------------------------------------------------------
// sspq_req_if: request channel
// Valid/ready channel that carries one request word per handshake.
// ----------------------------------------------------------------------------
interface sspq_req_if;
   import sspq_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

FILE: rtl/sspq_rsp_if.sv
// ----------------------------------------------------------------------------
// sspq_rsp_if: response channel
// Valid/ready channel that carries one response word per handshake.
// ----------------------------------------------------------------------------
interface sspq_rsp_if;
   import sspq_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

FILE: rtl/sspq_cell.sv
// ----------------------------------------------------------------------------
// sspq_cell: one slot of the sorted chain
// Holds one entry, compares it with the incoming key and takes either its
// own value, the new entry, or a neighbor's entry.
// ----------------------------------------------------------------------------
module sspq_cell
   import sspq_pkg::*;
(
   input  logic         clock,
   input  cell_cmd_type cmd,
   input  logic         occupied,
   input  logic         at_tail,
   input  logic         left_gt,
   input  entry_type    left_entry,
   input  entry_type    right_entry,
   output logic         gt,
   output entry_type    entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // Strictly greater keys move back, so equal keys keep arrival order.
   assign gt    = occupied && (entry_ff.key > cmd.item.key);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.enq) begin
         if (left_gt) begin
            entry_in = left_entry;
         end else if (gt || at_tail) begin
            entry_in = cmd.item;
         end
      end else if (cmd.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: rtl/stable_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue: sorted-list priority queue on a cell chain
// The queue keeps up to DEPTH entries in a row of cells ordered by ascending
// signed key, the front cell holding the smallest. An enqueue word carries a
// key and a handle; every cell compares its key with the new one in the same
// cycle, cells with a strictly greater key step one place back and the new
// entry drops into the gap, so entries with equal keys leave in the order
// they arrived. A dequeue word returns the front entry and every cell takes
// its right neighbor's entry. Each request produces exactly one response
// word, which carries the dequeued entry (or zeros), a status (ok, enqueue
// dropped because full, dequeue on empty), the empty flag and the entry
// count after the step. The response word is registered in the cycle after
// the request is accepted, and one request can be accepted every cycle as
// long as the response side keeps taking words. The cycle is set by the
// parallel key compare across all cells plus the selection of each cell's
// next entry. No clearing pass is needed after reset; the entry count alone
// decides which cells hold data.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue
   import sspq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   sspq_req_if.sink  req_chan,
   sspq_rsp_if.source rsp_chan
);

   // Fill count: cells below it hold valid entries.
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;

   // Response register; it frees up as soon as the sink takes the word.
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_word_type rsp_data_ff;
   rsp_word_type rsp_data_in;

   logic         accept;
   logic         is_full;
   logic         is_empty;
   cell_cmd_type cmd;

   entry_type cell_entry [DEPTH];
   logic      cell_gt    [DEPTH];

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign is_full  = (count_ff == COUNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);

   // Command for the chain; a full enqueue or an empty dequeue leaves all
   // cells untouched.
   always_comb begin
      cmd.enq         = accept && (req_chan.data.op == OP_ENQUEUE) && !is_full;
      cmd.deq         = accept && (req_chan.data.op == OP_DEQUEUE) && !is_empty;
      cmd.item.key    = req_chan.data.key;
      cmd.item.handle = req_chan.data.payload[HANDLE_KEEP_W-1:0];
   end

   // The chain of cells. Each cell sees its left neighbor's compare result
   // and entry for the shift on enqueue, and its right neighbor's entry for
   // the shift on dequeue.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic      left_gt;
      entry_type left_entry;
      entry_type right_entry;

      if (i == 0) begin : g_head
         assign left_gt    = 1'b0;
         assign left_entry = cmd.item;
      end else begin : g_body
         assign left_gt    = cell_gt[i-1];
         assign left_entry = cell_entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      sspq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (COUNT_W'(i) < count_ff),
         .at_tail     (COUNT_W'(i) == count_ff),
         .left_gt     (left_gt),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .gt          (cell_gt[i]),
         .entry       (cell_entry[i])
      );
   end

   // Next count and the response word of the accepted request.
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;

      if (cmd.enq) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (cmd.deq) begin
         count_in = count_ff - COUNT_W'(1);
      end

      if (accept) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.out_valid = cmd.deq;
         rsp_data_in.out_key   = cmd.deq ? cell_entry[0].key : '0;
         rsp_data_in.out_payload = cmd.deq ? PAYLOAD_W'(cell_entry[0].handle) : '0;
         if ((req_chan.data.op == OP_ENQUEUE) && is_full) begin
            rsp_data_in.status = STATUS_FULL;
         end else if ((req_chan.data.op == OP_DEQUEUE) && is_empty) begin
            rsp_data_in.status = STATUS_EMPTY;
         end else begin
            rsp_data_in.status = STATUS_OK;
         end
         rsp_data_in.empty_res = (count_in == '0);
         rsp_data_in.count     = COUNT_OUT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule

FILE: rtl/sspq_checker.sv
// ----------------------------------------------------------------------------
// sspq_checker: port-level checks of the priority queue
// Watches the request and response channels and checks the response words
// for consistency with each other and with the handshake.
// ----------------------------------------------------------------------------
module sspq_checker
   import sspq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_word_type rsp_data
);

   // A stalled response word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // Every accepted request yields a response word in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request produced no response word");

   // The empty flag agrees with the count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.empty_res == (rsp_data.count == '0)))
      else $error("empty flag disagrees with count");

   // A dropped enqueue is reported only with a full store.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_FULL)
         |-> (rsp_data.count == COUNT_OUT_W'(DEPTH)) && !rsp_data.out_valid)
      else $error("full status with store not full");

   // A returned entry comes only with an ok status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_valid |-> (rsp_data.status == STATUS_OK))
      else $error("returned entry with error status");

endmodule

bind stable_sorted_priority_queue sspq_checker u_sspq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

FILE: test/stable_sorted_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_tb: self-checking bench for the sorted queue
// Drives enqueue and dequeue words into the queue, predicts every response
// word with a behavioral copy of the sorted store, and compares each
// response field by field. It covers empty and full boundaries, key
// extremes and tie ordering, and then runs long random traffic under
// several source-idle and sink-stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stable_sorted_priority_queue_tb;
   import sspq_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 10;
   localparam logic [PAYLOAD_W-1:0] HANDLE_MASK =
      PAYLOAD_W'((64'd1 << HANDLE_KEEP_W) - 64'd1);

   logic clock;
   logic reset;
   int   cycle_count;
   int   fail_count;

   // Percentages of cycles in which the source holds back or the sink stalls.
   int   send_idle_pct;
   int   recv_stall_pct;

   sspq_req_if req_bus ();
   sspq_rsp_if rsp_bus ();

   stable_sorted_priority_queue uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Behavioral copy of the sorted store: entries below store_fill are valid,
   // index 0 holds the smallest key.
   logic signed [KEY_W-1:0] store_keys    [DEPTH];
   logic [PAYLOAD_W-1:0]    store_handles [DEPTH];
   int                      store_fill;

   // Response words still owed by the queue, oldest first.
   rsp_word_type expected_results [$];
   rsp_word_type oldest_result;

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t ns: timeout with %0d responses outstanding", $time,
                  expected_results.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Sink side: stalls at random at the rate of the current phase.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Applies one accepted request word to the store copy and returns the
   // response word the queue must produce for it.
   function automatic rsp_word_type sorted_store_step(req_word_type w);
      rsp_word_type r;
      int pos;
      int i;
      r = '0;
      r.status = STATUS_OK;
      if (w.op == OP_ENQUEUE) begin
         if (store_fill >= DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            // The new entry goes behind every entry with an equal or smaller
            // key, which keeps equal keys in arrival order.
            pos = 0;
            while (pos < store_fill && $signed(store_keys[pos]) <= $signed(w.key))
               pos++;
            for (i = store_fill; i > pos; i--) begin
               store_keys[i]    = store_keys[i-1];
               store_handles[i] = store_handles[i-1];
            end
            store_keys[pos]    = w.key;
            store_handles[pos] = w.payload & HANDLE_MASK;
            store_fill++;
         end
      end else if (store_fill == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         r.out_valid   = 1'b1;
         r.out_key     = store_keys[0];
         r.out_payload = store_handles[0];
         for (i = 1; i < store_fill; i++) begin
            store_keys[i-1]    = store_keys[i];
            store_handles[i-1] = store_handles[i];
         end
         store_fill--;
      end
      r.empty_res = (store_fill == 0);
      r.count     = COUNT_OUT_W'(store_fill);
      return r;
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         fail_count++;
      end
   endfunction

   // Compares every response word taken by the sink with the oldest
   // outstanding prediction.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t ns: response word with none expected, actual %0h", $time,
                     rsp_bus.data);
            fail_count++;
         end else begin
            oldest_result = expected_results.pop_front();
            check_field("out_valid",   oldest_result.out_valid,   rsp_bus.data.out_valid);
            check_field("out_key",     oldest_result.out_key,     rsp_bus.data.out_key);
            check_field("out_payload", oldest_result.out_payload, rsp_bus.data.out_payload);
            check_field("status",      oldest_result.status,      rsp_bus.data.status);
            check_field("empty_res",   oldest_result.empty_res,   rsp_bus.data.empty_res);
            check_field("count",       oldest_result.count,       rsp_bus.data.count);
         end
      end
   end

   // Sends one request word; called at a rising edge and returns at the edge
   // where the word was accepted. Valid stays high for a following word
   // unless that word chooses to leave a gap first.
   task automatic send_word(input op_type op, input logic signed [KEY_W-1:0] key,
                            input logic [PAYLOAD_W-1:0] payload);
      req_word_type w;
      int gap;
      w.op      = op;
      w.key     = key;
      w.payload = payload;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 20)
         gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= w;
      do @(posedge clock); while (!req_bus.ready);
      expected_results.push_back(sorted_store_step(w));
   endtask

   task automatic test_dequeue_on_empty();
      send_word(OP_DEQUEUE, 32'sh7fff_ffff, 16'hffff);
   endtask

   // Fills the store to the brim with key extremes and repeated keys, so the
   // drain afterwards shows both the sort and the tie order.
   task automatic test_fill_with_extremes();
      logic signed [KEY_W-1:0] keys [DEPTH] = '{
         32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0000, -32'sd1,
         32'sd5, 32'sd5, 32'sh8000_0001, 32'sh7fff_fffe,
         32'sd5, -32'sd1, 32'sd0, 32'sh8000_0000,
         32'sh7fff_ffff, -32'sd100, 32'sd100, 32'sd42};
      for (int i = 0; i < DEPTH; i++)
         send_word(OP_ENQUEUE, keys[i], (i == 0) ? 16'h0000 :
                   (i == 1) ? 16'hffff : PAYLOAD_W'(16'h1111 * i));
   endtask

   task automatic test_enqueue_when_full();
      send_word(OP_ENQUEUE, 32'sh8000_0000, 16'ha5a5);
   endtask

   task automatic test_dequeue_order();
      repeat (4) send_word(OP_DEQUEUE, 32'($urandom), 16'($urandom));
   endtask

   function automatic logic signed [KEY_W-1:0] pick_key();
      case ($urandom_range(3))
         0: return 32'($urandom);
         1: return $signed(32'($urandom_range(8))) - 32'sd4;
         2: return $urandom_range(1) ? 32'sh8000_0000 + 32'($urandom_range(2))
                                     : 32'sh7fff_ffff - 32'($urandom_range(2));
         default: return $signed(32'($urandom_range(40))) - 32'sd20;
      endcase
   endfunction

   // Random traffic in bursts, each burst leaning toward enqueues, dequeues
   // or neither, so the store swings between empty and full many times.
   task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct);
      int sent;
      int burst;
      int enq_pct;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      while (sent < items) begin
         burst = $urandom_range(8, 40);
         case ($urandom_range(2))
            0: enq_pct = 15;
            1: enq_pct = 50;
            default: enq_pct = 85;
         endcase
         for (int i = 0; i < burst && sent < items; i++) begin
            if ($urandom_range(99) < enq_pct)
               send_word(OP_ENQUEUE, pick_key(), 16'($urandom));
            else
               send_word(OP_DEQUEUE, 32'($urandom), 16'($urandom));
            sent++;
         end
      end
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      cycle_count    = 0;
      fail_count     = 0;
      store_fill     = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      req_bus.valid  = 1'b0;
      req_bus.data   = '0;
      rsp_bus.ready  = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_dequeue_on_empty();
      test_fill_with_extremes();
      test_enqueue_when_full();
      test_dequeue_order();

      test_random_traffic(475, 0, 0);
      test_random_traffic(475, 54, 0);
      test_random_traffic(475, 0, 54);
      test_random_traffic(475, 37, 37);
      req_bus.valid <= 1'b0;

      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
